// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the converter RTL
// Clocked property checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== sv/iptp_pkg.sv =====
// ----------------------------------------------------------------------------
// iptp_pkg
// Types, character codes and helpers for the infix to postfix converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iptp_pkg;

  // Operator stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CHAR_W      = 8;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_Z   = 8'h7A;

  typedef struct packed {
    logic [CHAR_W-1:0] symbol;
    logic              finish;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last;
    logic              overflow_seen;
    logic              underflow_seen;
  } out_item_t;

  // Sequencer to output buffer
  typedef struct packed {
    logic      emit;
    logic      flush;
    out_item_t item;
  } obuf_cmd_t;

  // Output buffer to sequencer
  typedef struct packed {
    logic can_emit;
    logic can_flush;
  } obuf_stat_t;

  // Operator precedence; '(' and unknown characters rank 0
  function automatic logic [1:0] prec_of(input logic [CHAR_W-1:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
    if (c == CH_CARET) p = 2'd3;
    return p;
  endfunction

endpackage

// ===== sv/infix_to_postfix_converter.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: infix characters in, postfix characters out,
// operator stack held in a synchronous RAM with a cached top entry.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_item_i carries one character
//   (symbol) or an end-of-expression mark (finish). Output channel
//   out_valid_o / out_stall_i / out_item_o carries postfix characters; the
//   final result of each input item has last set, and the zero terminator
//   after finish reports the sticky overflow and underflow flags.
//   An item that yields no character yields no result.
//   Items are taken one at a time; the input stalls until the current item
//   is done. Closing an all-zero run emits its '0', and each stack entry
//   popped takes one RAM read to refresh the cached top, also the '(' that a
//   ')' discards. One result is held back until the item ends to set last.
//   A stalled output holds its item; the sequencer waits whenever the
//   one-deep holding slot is full and a stalled item sits in the output.
//   Reset clears the stack count, digit-run state and flags; stack RAM
//   contents read before being written are never used, so no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module infix_to_postfix_converter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  iptp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output iptp_pkg::out_item_t out_item_o
);

  import iptp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOSE,
    S_BODY,
    S_POP,
    S_WAIT,
    S_FLUSH
  } state_e;

  state_e            state_q, state_d;
  logic [CHAR_W-1:0] sym_q, sym_d;
  logic              fin_q, fin_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CHAR_W-1:0] top_q, top_d;
  logic              in_num_q, in_num_d;
  logic              oz_q, oz_d;
  logic              ovf_q, ovf_d;
  logic              unf_q, unf_d;
  logic              done_q, done_d;

  obuf_cmd_t         obuf_cmd;
  obuf_stat_t        obuf_stat;
  logic              ram_we, ram_re;
  logic [CHAR_W-1:0] ram_rdata;
  logic [CNT_W-1:0]  cnt_m2;

  logic              is_digit, is_letter, has_entry, oz_eff;

  assign is_digit  = !fin_q && (sym_q >= CH_ZERO) && (sym_q <= CH_NINE);
  assign is_letter = ((sym_q >= CH_LC_A) && (sym_q <= CH_LC_Z)) ||
                     ((sym_q >= CH_UC_A) && (sym_q <= CH_UC_Z));
  assign has_entry = (count_q != '0);
  assign oz_eff    = in_num_q ? oz_q : 1'b1;
  assign cnt_m2    = count_q - CNT_W'(2);

  // Stack storage
  iptp_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (CHAR_W)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (sym_q),
    .re_i    (ram_re),
    .raddr_i (cnt_m2[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Result holding slot and output register
  iptp_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (obuf_cmd),
    .stat_o      (obuf_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  assign in_stall_o = (state_q != S_IDLE);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    sym_d    = sym_q;
    fin_d    = fin_q;
    count_d  = count_q;
    top_d    = top_q;
    in_num_d = in_num_q;
    oz_d     = oz_q;
    ovf_d    = ovf_q;
    unf_d    = unf_q;
    done_d   = done_q;
    obuf_cmd = '0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sym_d   = in_item_i.symbol;
          fin_d   = in_item_i.finish;
          state_d = S_CLOSE;
        end
      end

      // Digits, or closing of a pending digit run
      S_CLOSE: begin
        if (is_digit) begin
          if (oz_eff && sym_q == CH_ZERO) begin
            in_num_d = 1'b1;
            oz_d     = 1'b1;
            state_d  = S_FLUSH;
          end else if (obuf_stat.can_emit) begin
            obuf_cmd.emit          = 1'b1;
            obuf_cmd.item.out_char = sym_q;
            in_num_d               = 1'b1;
            oz_d                   = 1'b0;
            state_d                = S_FLUSH;
          end
        end else if (in_num_q) begin
          if (obuf_stat.can_emit) begin
            obuf_cmd.emit = 1'b1;
            if (oz_q) begin
              obuf_cmd.item.out_char = CH_ZERO;
              oz_d                   = 1'b0;
            end else begin
              obuf_cmd.item.out_char = CH_SPACE;
              in_num_d               = 1'b0;
              state_d                = S_BODY;
            end
          end
        end else begin
          state_d = S_BODY;
        end
      end

      // Letters pass, '(' is pushed, everything else goes on to S_POP
      S_BODY: begin
        if (fin_q) begin
          state_d = S_POP;
        end else if (is_letter) begin
          if (obuf_stat.can_emit) begin
            obuf_cmd.emit          = 1'b1;
            obuf_cmd.item.out_char = sym_q;
            state_d                = S_FLUSH;
          end
        end else if (sym_q == CH_LPAREN) begin
          if (count_q < CNT_W'(STACK_DEPTH)) begin
            ram_we  = 1'b1;
            top_d   = sym_q;
            count_d = count_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          state_d = S_FLUSH;
        end else begin
          state_d = S_POP;
        end
      end

      // At most one pop per visit; new top is read back in S_WAIT
      S_POP: begin
        if (fin_q) begin
          if (has_entry) begin
            if (top_q == CH_LPAREN || obuf_stat.can_emit) begin
              obuf_cmd.emit          = (top_q != CH_LPAREN);
              obuf_cmd.item.out_char = top_q;
              count_d                = count_q - CNT_W'(1);
              ram_re                 = 1'b1;
              done_d                 = 1'b0;
              state_d                = S_WAIT;
            end
          end else if (obuf_stat.can_emit) begin
            obuf_cmd.emit                = 1'b1;
            obuf_cmd.item.out_char       = CH_NUL;
            obuf_cmd.item.overflow_seen  = ovf_q;
            obuf_cmd.item.underflow_seen = unf_q;
            ovf_d                        = 1'b0;
            unf_d                        = 1'b0;
            state_d                      = S_FLUSH;
          end
        end else if (sym_q == CH_RPAREN) begin
          if (obuf_stat.can_emit) begin
            obuf_cmd.emit = 1'b1;
            if (has_entry && top_q != CH_LPAREN) begin
              obuf_cmd.item.out_char = top_q;
              count_d                = count_q - CNT_W'(1);
              ram_re                 = 1'b1;
              done_d                 = 1'b0;
              state_d                = S_WAIT;
            end else if (has_entry) begin
              // matching open paren: discard it
              obuf_cmd.item.out_char = CH_SPACE;
              count_d                = count_q - CNT_W'(1);
              ram_re                 = 1'b1;
              done_d                 = 1'b1;
              state_d                = S_WAIT;
            end else begin
              obuf_cmd.item.out_char = CH_SPACE;
              unf_d                  = 1'b1;
              state_d                = S_FLUSH;
            end
          end
        end else begin
          if (has_entry && (prec_of(sym_q) <= prec_of(top_q))) begin
            if (obuf_stat.can_emit) begin
              obuf_cmd.emit          = 1'b1;
              obuf_cmd.item.out_char = top_q;
              count_d                = count_q - CNT_W'(1);
              ram_re                 = 1'b1;
              done_d                 = 1'b0;
              state_d                = S_WAIT;
            end
          end else begin
            if (count_q < CNT_W'(STACK_DEPTH)) begin
              ram_we  = 1'b1;
              top_d   = sym_q;
              count_d = count_q + CNT_W'(1);
            end else begin
              ovf_d = 1'b1;
            end
            state_d = S_FLUSH;
          end
        end
      end

      // Refresh the cached top from the RAM
      S_WAIT: begin
        top_d   = ram_rdata;
        state_d = done_q ? S_FLUSH : S_POP;
      end

      // Release the held result with last set
      S_FLUSH: begin
        if (obuf_stat.can_flush) begin
          obuf_cmd.flush = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      sym_q    <= '0;
      fin_q    <= 1'b0;
      count_q  <= '0;
      top_q    <= '0;
      in_num_q <= 1'b0;
      oz_q     <= 1'b0;
      ovf_q    <= 1'b0;
      unf_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      sym_q    <= sym_d;
      fin_q    <= fin_d;
      count_q  <= count_d;
      top_q    <= top_d;
      in_num_q <= in_num_d;
      oz_q     <= oz_d;
      ovf_q    <= ovf_d;
      unf_q    <= unf_d;
      done_q   <= done_d;
    end
  end

  `ASSERT_CLK(a_count_range, count_q <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
  `ASSERT_CLK(a_emit_room, obuf_cmd.emit |-> obuf_stat.can_emit, "emit without room")
  `ASSERT_CLK(a_push_room, ram_we |-> (count_q < CNT_W'(STACK_DEPTH)), "push onto full stack")
  `ASSERT_CLK(a_pop_refresh, ram_re |=> (state_q == S_WAIT), "pop without top refresh")
  `ASSERT_CLK(a_accept_busy, (in_valid_i && !in_stall_o) |=> (state_q == S_CLOSE), "accept not followed by work")

endmodule

// ===== sv/iptp_ram.sv =====
// ----------------------------------------------------------------------------
// iptp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iptp_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/iptp_outbuf.sv =====
// ----------------------------------------------------------------------------
// iptp_outbuf
// Holds back one result so that the last flag can be set once the item ends,
// and presents results on a registered valid/stall output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iptp_outbuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  iptp_pkg::obuf_cmd_t  cmd_i,
  output iptp_pkg::obuf_stat_t stat_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output iptp_pkg::out_item_t  out_item_o
);

  import iptp_pkg::*;

  logic      pend_v_q, pend_v_d;
  out_item_t pend_q, pend_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;
  logic      out_free;

  assign out_free         = !out_valid_q || !out_stall_i;
  assign stat_o.can_emit  = !pend_v_q || out_free;
  assign stat_o.can_flush = !pend_v_q || out_free;

  // Pending slot and output register update
  always_comb begin
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.emit) begin
      if (pend_v_q) begin
        out_item_d      = pend_q;
        out_item_d.last = 1'b0;
        out_valid_d     = 1'b1;
      end
      pend_d   = cmd_i.item;
      pend_v_d = 1'b1;
    end else if (cmd_i.flush && pend_v_q) begin
      out_item_d      = pend_q;
      out_item_d.last = 1'b1;
      out_valid_d     = 1'b1;
      pend_v_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `ASSERT_NEVER(a_emit_and_flush, cmd_i.emit && cmd_i.flush, "emit and flush together")
  `ASSERT_CLK(a_emit_room, (cmd_i.emit && pend_v_q) |-> out_free, "emit would drop an item")
  `ASSERT_CLK(a_flush_last, (cmd_i.flush && pend_v_q && out_free) |=> (out_valid_q && out_item_q.last), "flushed item not marked last")

endmodule
